[hw/rtl/sha256_pkg.sv]
// Shared types and constants of the SHA-256 byte stream hasher.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sha256_pkg;

   // Byte source for a push into the block buffer.
   localparam logic [1:0] BSEL_DATA = 2'd0;
   localparam logic [1:0] BSEL_PAD  = 2'd1;
   localparam logic [1:0] BSEL_ZERO = 2'd2;
   localparam logic [1:0] BSEL_LEN  = 2'd3;

   localparam logic [5:0] ROUND_LAST  = 6'd63;
   localparam logic [4:0] DIGEST_LAST = 5'd31;
   localparam logic [7:0] PAD_BYTE    = 8'h80;
   localparam logic [63:0] BYTE_BITS  = 64'd8;

   localparam logic [31:0] HASH_INIT [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       push;
      logic [1:0] byte_sel;
      logic       count_en;
      logic       round_en;
      logic [5:0] round_idx;
      logic       add_hash;
      logic       restart;
      logic [4:0] digest_pos;
   } sha256_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic fill_last;
      logic len_zone;
   } sha256_stat_type;

endpackage

`default_nettype wire

[hw/rtl/sha256_if.sv]
// Valid/ready channel interfaces for the request and response sides.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

interface sha256_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] data_byte;

   modport source (output valid, output op, output data_byte, input ready);
   modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface sha256_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] digest_byte;
   logic [4:0] byte_position;
   logic       last_byte;

   modport source (output valid, output digest_byte, output byte_position,
                   output last_byte, input ready);
   modport sink   (input valid, input digest_byte, input byte_position,
                   input last_byte, output ready);
endinterface

`default_nettype wire

[hw/rtl/sha256_ctrl.sv]
// Controller of the SHA-256 hasher: sequences byte pushes, padding,
// compression rounds and digest output. Depends on sha256_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sha256_ctrl
   import sha256_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic            req_op,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output logic [4:0]           rsp_position,
   output logic                 rsp_last,
   input  wire sha256_stat_type stat,
   output sha256_cmd_type       cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PAD  = 3'd1;
   localparam logic [2:0] ST_COMP = 3'd2;
   localparam logic [2:0] ST_FIN  = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [5:0] round_ff, round_in;
   logic [4:0] pos_ff, pos_in;
   logic       finishing_ff, finishing_in;
   logic       len_ok_ff, len_ok_in;

   always_comb begin
      state_in     = state_ff;
      round_in     = round_ff;
      pos_in       = pos_ff;
      finishing_in = finishing_ff;
      len_ok_in    = len_ok_ff;
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      cmd          = '0;
      cmd.round_idx  = round_ff;
      cmd.digest_pos = pos_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.push = 1'b1;
               if (req_op) begin
                  // The pad byte goes in at once; the length fits in this
                  // block only if the pad byte lands before the length field.
                  cmd.byte_sel = BSEL_PAD;
                  finishing_in = 1'b1;
                  len_ok_in    = ~stat.len_zone;
               end else begin
                  cmd.byte_sel = BSEL_DATA;
                  cmd.count_en = 1'b1;
                  finishing_in = 1'b0;
               end
               if (stat.fill_last) begin
                  state_in = ST_COMP;
                  round_in = '0;
               end else if (req_op) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            cmd.push     = 1'b1;
            cmd.byte_sel = (len_ok_ff && stat.len_zone) ? BSEL_LEN : BSEL_ZERO;
            if (stat.fill_last) begin
               state_in = ST_COMP;
               round_in = '0;
            end
         end
         ST_COMP: begin
            cmd.round_en = 1'b1;
            round_in     = round_ff + 6'd1;
            if (round_ff == ROUND_LAST) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            cmd.add_hash = 1'b1;
            if (!finishing_ff) begin
               state_in = ST_IDLE;
            end else if (len_ok_ff) begin
               state_in = ST_EMIT;
               pos_in   = '0;
            end else begin
               // First of two final blocks done; the length goes in the next.
               len_ok_in = 1'b1;
               state_in  = ST_PAD;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (pos_ff == DIGEST_LAST) begin
                  cmd.restart  = 1'b1;
                  finishing_in = 1'b0;
                  state_in     = ST_IDLE;
               end else begin
                  pos_in = pos_ff + 5'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         round_ff     <= '0;
         pos_ff       <= '0;
         finishing_ff <= 1'b0;
         len_ok_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         pos_ff       <= pos_in;
         finishing_ff <= finishing_in;
         len_ok_ff    <= len_ok_in;
      end
   end

   assign rsp_position = pos_ff;
   assign rsp_last     = (pos_ff == DIGEST_LAST);

endmodule

`default_nettype wire

[hw/rtl/sha256_dp.sv]
// Datapath of the SHA-256 hasher: byte packer, 16-word schedule window,
// working variables, chaining words and bit count. Depends on sha256_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sha256_dp
   import sha256_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire sha256_cmd_type cmd,
   input  wire logic [7:0]     req_data_byte,
   output sha256_stat_type     stat,
   output logic [7:0]          digest_byte
);

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

   logic [5:0]  fill_ff;
   logic [63:0] count_ff;
   logic [23:0] acc_ff;
   logic [31:0] w_ff [16];
   logic [31:0] v_ff [8];
   logic [31:0] h_ff [8];

   logic [7:0]  push_byte;
   logic [63:0] len_shift;
   logic [31:0] w_next, t1, t2, digest_word, digest_shift;

   assign stat.fill_last = (fill_ff == 6'd63);
   assign stat.len_zone  = (fill_ff[5:3] == 3'b111);

   // Length bytes go out most significant first at fill positions 56..63.
   assign len_shift = count_ff << {fill_ff[2:0], 3'b000};

   always_comb begin
      unique case (cmd.byte_sel)
         BSEL_DATA: push_byte = req_data_byte;
         BSEL_PAD:  push_byte = PAD_BYTE;
         BSEL_ZERO: push_byte = 8'h00;
         BSEL_LEN:  push_byte = len_shift[63:56];
      endcase
   end

   assign w_next = small_sigma1(w_ff[14]) + w_ff[9] + small_sigma0(w_ff[1]) + w_ff[0];
   assign t1 = v_ff[7] + big_sigma1(v_ff[4]) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
             + ROUND_K[cmd.round_idx] + w_ff[0];
   assign t2 = big_sigma0(v_ff[0])
             + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));

   assign digest_word  = h_ff[cmd.digest_pos[4:2]];
   assign digest_shift = digest_word << {cmd.digest_pos[1:0], 3'b000};
   assign digest_byte  = digest_shift[31:24];

   // Control state: fill position, bit count and chaining words.
   always_ff @(posedge clock) begin
      if (reset || cmd.restart) begin
         fill_ff  <= '0;
         count_ff <= '0;
         for (int i = 0; i < 8; i++) begin
            h_ff[i] <= HASH_INIT[i];
         end
      end else begin
         if (cmd.push) begin
            fill_ff <= fill_ff + 6'd1;
         end
         if (cmd.push && cmd.count_en) begin
            count_ff <= count_ff + BYTE_BITS;
         end
         if (cmd.add_hash) begin
            for (int i = 0; i < 8; i++) begin
               h_ff[i] <= h_ff[i] + v_ff[i];
            end
         end
      end
   end

   // Payload: byte packer, schedule window and working variables.
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         acc_ff <= {acc_ff[15:0], push_byte};
         if (fill_ff[1:0] == 2'b11) begin
            for (int i = 0; i < 15; i++) begin
               w_ff[i] <= w_ff[i + 1];
            end
            w_ff[15] <= {acc_ff, push_byte};
         end
         if (fill_ff == 6'd63) begin
            for (int i = 0; i < 8; i++) begin
               v_ff[i] <= h_ff[i];
            end
         end
      end else if (cmd.round_en) begin
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= w_ff[i + 1];
         end
         w_ff[15] <= w_next;
         v_ff[0] <= t1 + t2;
         v_ff[1] <= v_ff[0];
         v_ff[2] <= v_ff[1];
         v_ff[3] <= v_ff[2];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[5] <= v_ff[4];
         v_ff[6] <= v_ff[5];
         v_ff[7] <= v_ff[6];
      end
   end

endmodule

`default_nettype wire

[hw/rtl/sha256_byte_stream_hasher_core.sv]
// SHA-256 byte stream hasher. Data bytes are taken one per cycle while idle; the
// 64th byte of a block starts the one-round-per-cycle compression and the final
// chaining add, during which no request is taken.
// A finish pushes padding one byte per cycle (over one or two blocks),
// compresses, then offers 32 digest bytes, one per cycle while the sink is ready.
// Synchronous reset loads the initial hash values and clears the counters.
`timescale 1ns / 1ps
`default_nettype none

module sha256_byte_stream_hasher_core
   import sha256_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   sha256_req_if.sink   req_if,
   sha256_rsp_if.source rsp_if
);

   sha256_cmd_type  cmd;
   sha256_stat_type stat;

   sha256_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_if.valid),
      .req_op       (req_if.op),
      .req_ready    (req_if.ready),
      .rsp_valid    (rsp_if.valid),
      .rsp_ready    (rsp_if.ready),
      .rsp_position (rsp_if.byte_position),
      .rsp_last     (rsp_if.last_byte),
      .stat         (stat),
      .cmd          (cmd)
   );

   sha256_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_data_byte (req_if.data_byte),
      .stat          (stat),
      .digest_byte   (rsp_if.digest_byte)
   );

   // Requests are never taken while a digest is being offered.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_if.ready && rsp_if.valid))
      else $error("request accepted during digest output");

   // The last digest transfer returns the block to accepting requests.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.ready && rsp_if.last_byte) |=> req_if.ready)
      else $error("block not ready after last digest byte");

   // Digest positions advance by one per transfer within a run.
   a_position: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.ready && !rsp_if.last_byte) |=>
      (rsp_if.valid && rsp_if.byte_position == 5'($past(rsp_if.byte_position) + 5'd1)))
      else $error("digest position did not advance");

   // A finish request never starts digest output in the next cycle.
   a_finish_delay: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready && req_if.op) |=> !rsp_if.valid)
      else $error("digest offered before compression");

endmodule

`default_nettype wire
